// ----- src/odo_pkg.sv -----
// ----------------------------------------------------------------------------
// odo_pkg: shared types and constants for the wheel odometry core
// widths of the fixed-point fields, the shared multiplier and the rate divider
// ----------------------------------------------------------------------------
package odo_pkg;

    // field widths
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CFG_W           = 24;
    localparam int ARC_W           = 32;
    localparam int ACC_W           = 48;
    localparam int DT_W            = 20;
    localparam int CFG_IDX_W       = 2;
    localparam int MAG_EXT_W       = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MM_PER_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_RADIUS = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] MM_PER_COUNT_RST     = 24'd18300;
    localparam logic [CFG_W-1:0] INV_TRACK_WIDTH_RST  = 24'd209715;
    localparam logic [CFG_W-1:0] INV_WHEEL_RADIUS_RST = 24'd1048576;

    // shared multiplier: signed a times signed b, registered product
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // rate path: |arc| * inv_radius, then times 1e6 in two halves
    localparam int US_PER_S  = 1000000;
    localparam int P1_W      = ARC_W + CFG_W;
    localparam int P1_LO_W   = P1_W / 2;
    localparam int P1_HI_W   = P1_W - P1_LO_W;
    localparam int US_W      = 20;
    localparam int HI_PROD_W = P1_HI_W + US_W;
    localparam int LO_PROD_W = P1_LO_W + US_W;
    localparam int N_FULL_W  = P1_W + US_W;

    // rate divider, two quotient bits per cycle
    localparam int DIV_Q_W   = 32;
    localparam int DIV_N_W   = N_FULL_W - CFG_W;
    localparam int DIV_R_W   = DIV_N_W - DIV_Q_W;
    localparam int DIV_STEPS = DIV_Q_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic done;
        logic ovf;
    } div_sts_t;

endpackage

// ----- src/diff_drive_wheel_odometry_core.sv -----
// ----------------------------------------------------------------------------
// diff_drive_wheel_odometry_core: differential drive wheel odometry
// wheel arcs, forward change, rotation, wheel rates and running totals from
// two absolute encoder counts, on one shared multiplier and one divider
// ----------------------------------------------------------------------------
//  channel   signals                                   direction  beat
//  in        in_valid/in_ready, action, counts, dt_us  sink       one sample
//  out       out_valid/out_ready, seven result fields  source     one result
//  cfg       cfg_write, cfg_index, cfg_data            sink       one register
//
//  an update beat runs the arc, sum, rotation and heading steps, and then the
//  rate path for each wheel unless dt_us is zero; a reset action goes straight
//  to hand-off; the rate path dominates: per wheel 3 multiplier passes, a sum,
//  a divider start, the divider wait and a result step
//  in_ready is high only while the sequencer is idle
//  a finished result waits in the sequencer until the output register is free,
//  so a stalled output holds back the next sample only at hand-off
//  rst_n clears the baseline counts, totals and handshake state, and loads
//  the register defaults
// ----------------------------------------------------------------------------
module diff_drive_wheel_odometry_core #(
    parameter int COUNT_WIDTH = odo_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_write,
    input  logic [odo_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [odo_pkg::CFG_W-1:0]            cfg_data,
    // input samples
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 action,
    input  logic signed [COUNT_WIDTH-1:0]        left_count,
    input  logic signed [COUNT_WIDTH-1:0]        right_count,
    input  logic [odo_pkg::DT_W-1:0]             dt_us,
    // results
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [odo_pkg::ARC_W-1:0]     fwd_change,
    output logic signed [odo_pkg::ARC_W-1:0]     rot_change,
    output logic signed [odo_pkg::ARC_W-1:0]     omega_left,
    output logic signed [odo_pkg::ARC_W-1:0]     omega_right,
    output logic [odo_pkg::ACC_W-1:0]            distance_total,
    output logic signed [odo_pkg::ACC_W-1:0]     heading_total,
    output logic                                 dt_zero
);
    import odo_pkg::*;

    // sequencer states
    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_ARC_L     = 5'd1;
    localparam logic [4:0] ST_ARC_R     = 5'd2;
    localparam logic [4:0] ST_ARC_SAT   = 5'd3;
    localparam logic [4:0] ST_SUM       = 5'd4;
    localparam logic [4:0] ST_ROT_MUL   = 5'd5;
    localparam logic [4:0] ST_ROT_SAT   = 5'd6;
    localparam logic [4:0] ST_HEAD      = 5'd7;
    localparam logic [4:0] ST_RATE_MUL  = 5'd8;
    localparam logic [4:0] ST_RATE_HI   = 5'd9;
    localparam logic [4:0] ST_RATE_LO   = 5'd10;
    localparam logic [4:0] ST_RATE_ADD  = 5'd11;
    localparam logic [4:0] ST_DIV_START = 5'd12;
    localparam logic [4:0] ST_DIV_WAIT  = 5'd13;
    localparam logic [4:0] ST_OMEGA     = 5'd14;
    localparam logic [4:0] ST_FINISH    = 5'd15;

    localparam logic [ARC_W-1:0] ARC_POS_MAX = {1'b0, {(ARC_W-1){1'b1}}};
    localparam logic [ARC_W-1:0] ARC_NEG_MAG = {1'b1, {(ARC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] ACC_U_MAX   = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] ACC_S_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_S_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

    // saturated arc magnitude from the count times mm_per_count product
    function automatic logic [ARC_W-1:0] arc_mag_sat(
        input logic [P1_W-1:0] p,
        input logic            neg,
        input logic            ovf,
        input logic            mm_zero
    );
        logic             big;
        logic [ARC_W-1:0] low;
        logic [ARC_W-1:0] res;
        big = (ovf && !mm_zero) || (|p[P1_W-1:ARC_W]);
        low = p[ARC_W-1:0];
        if (neg)
        begin
            res = (big || (low > ARC_NEG_MAG)) ? ARC_NEG_MAG : low;
        end
        else
        begin
            res = (big || low[ARC_W-1]) ? ARC_POS_MAX : low;
        end
        return res;
    endfunction

    // configuration registers
    logic [CFG_W-1:0] mm_reg;
    logic [CFG_W-1:0] itw_reg;
    logic [CFG_W-1:0] iwr_reg;

    // sequencer and state
    logic [4:0]             state_reg;
    logic [4:0]             state_next;
    logic                   wheel_reg;
    logic [COUNT_WIDTH-1:0] prev_left_reg;
    logic [COUNT_WIDTH-1:0] prev_right_reg;
    logic [ACC_W-1:0]       dist_reg;
    logic signed [ACC_W-1:0] head_reg;

    // working registers
    logic [ARC_W-1:0]        mag_l_reg;
    logic [ARC_W-1:0]        mag_r_reg;
    logic                    neg_l_reg;
    logic                    neg_r_reg;
    logic                    ovf_l_reg;
    logic                    ovf_r_reg;
    logic [DT_W-1:0]         dt_reg;
    logic signed [ARC_W-1:0] arc_l_reg;
    logic signed [ARC_W-1:0] arc_r_reg;
    logic [ARC_W-1:0]        amag_l_reg;
    logic [ARC_W-1:0]        amag_r_reg;
    logic signed [ARC_W-1:0] fwd_reg;
    logic signed [ARC_W:0]   diff_reg;
    logic signed [ARC_W-1:0] rot_reg;
    logic signed [ARC_W-1:0] om_l_reg;
    logic signed [ARC_W-1:0] om_r_reg;
    logic                    dtz_reg;
    logic [P1_LO_W-1:0]      lo_reg;
    logic [HI_PROD_W-1:0]    hi_reg;
    logic [DIV_N_W-1:0]      n_reg;

    // output register
    logic                    out_valid_reg;
    logic signed [ARC_W-1:0] fwd_out_reg;
    logic signed [ARC_W-1:0] rot_out_reg;
    logic signed [ARC_W-1:0] oml_out_reg;
    logic signed [ARC_W-1:0] omr_out_reg;
    logic [ACC_W-1:0]        dist_out_reg;
    logic signed [ACC_W-1:0] head_out_reg;
    logic                    dtz_out_reg;

    // shared units
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic                      div_start;
    logic [DIV_Q_W-1:0]        div_q;
    div_sts_t                  div_sts;

    // combinational helpers
    logic                    in_fire;
    logic                    out_free;
    logic [COUNT_WIDTH-1:0]  dl;
    logic [COUNT_WIDTH-1:0]  dr;
    logic [COUNT_WIDTH-1:0]  dl_mag;
    logic [COUNT_WIDTH-1:0]  dr_mag;
    logic [MAG_EXT_W-1:0]    dl_ext;
    logic [MAG_EXT_W-1:0]    dr_ext;
    logic [ARC_W-1:0]        arc_mag_new;
    logic                    arc_neg_sel;
    logic                    arc_ovf_sel;
    logic signed [ARC_W:0]   fwd_sum;
    logic [ARC_W-1:0]        fwd_mag;
    logic [ACC_W:0]          dist_sum;
    logic signed [ACC_W:0]   head_sum;
    logic signed [ARC_W-1:0] rot_new;
    logic [N_FULL_W-1:0]     n_full;
    logic                    om_neg;
    logic signed [ARC_W-1:0] om_new;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // wrapped count differences and their magnitudes
    always_comb
    begin
        dl     = COUNT_WIDTH'(left_count) - prev_left_reg;
        dr     = COUNT_WIDTH'(right_count) - prev_right_reg;
        dl_mag = dl[COUNT_WIDTH-1] ? (~dl + 1'b1) : dl;
        dr_mag = dr[COUNT_WIDTH-1] ? (~dr + 1'b1) : dr;
        dl_ext = MAG_EXT_W'(dl_mag);
        dr_ext = MAG_EXT_W'(dr_mag);
    end

    // arc saturation, left in ST_ARC_R and right in ST_ARC_SAT
    always_comb
    begin
        arc_neg_sel = (state_reg == ST_ARC_R) ? neg_l_reg : neg_r_reg;
        arc_ovf_sel = (state_reg == ST_ARC_R) ? ovf_l_reg : ovf_r_reg;
        arc_mag_new = arc_mag_sat(prod[P1_W-1:0], arc_neg_sel, arc_ovf_sel,
                                  (mm_reg == '0));
    end

    // forward change, totals and rotation
    always_comb
    begin
        fwd_sum  = (ARC_W+1)'(arc_l_reg) + (ARC_W+1)'(arc_r_reg);
        fwd_mag  = fwd_reg[ARC_W-1] ? (~fwd_reg + 1'b1) : fwd_reg;
        dist_sum = {1'b0, dist_reg} + (ACC_W+1)'(fwd_mag);
        head_sum = (ACC_W+1)'(head_reg) + (ACC_W+1)'(rot_reg);
        // floor shift by 24 keeps prod[MUL_P_W-1:CFG_W]; fits when the top
        // bits down to the result sign all agree
        if ((&prod[MUL_P_W-1:CFG_W+ARC_W-1]) || !(|prod[MUL_P_W-1:CFG_W+ARC_W-1]))
        begin
            rot_new = prod[CFG_W+ARC_W-1:CFG_W];
        end
        else
        begin
            rot_new = prod[MUL_P_W-1] ? $signed(ARC_NEG_MAG) : $signed(ARC_POS_MAX);
        end
    end

    // rate numerator: (hi * 1e6) << split plus lo * 1e6, then drop Q0.24
    assign n_full = (N_FULL_W'(hi_reg) << P1_LO_W) + N_FULL_W'(prod[LO_PROD_W-1:0]);

    // saturated, signed wheel rate from the divider
    always_comb
    begin
        om_neg = wheel_reg ? arc_r_reg[ARC_W-1] : arc_l_reg[ARC_W-1];
        if (om_neg)
        begin
            om_new = (div_sts.ovf || (div_q > ARC_NEG_MAG)) ? $signed(ARC_NEG_MAG)
                                                            : $signed(~div_q + 1'b1);
        end
        else
        begin
            om_new = (div_sts.ovf || div_q[DIV_Q_W-1]) ? $signed(ARC_POS_MAX)
                                                       : $signed(div_q);
        end
    end

    // multiplier operand select and divider start
    always_comb
    begin
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        case (state_reg)
            ST_ARC_L:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(mag_l_reg);
                mul_b  = MUL_B_W'(mm_reg);
            end
            ST_ARC_R:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(mag_r_reg);
                mul_b  = MUL_B_W'(mm_reg);
            end
            ST_ROT_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(diff_reg);
                mul_b  = MUL_B_W'(itw_reg);
            end
            ST_RATE_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(wheel_reg ? amag_r_reg : amag_l_reg);
                mul_b  = MUL_B_W'(iwr_reg);
            end
            ST_RATE_HI:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(prod[P1_W-1:P1_LO_W]);
                mul_b  = MUL_B_W'(US_PER_S);
            end
            ST_RATE_LO:
            begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'(lo_reg);
                mul_b  = MUL_B_W'(US_PER_S);
            end
            ST_DIV_START:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = action ? ST_FINISH : ST_ARC_L;
                end
            end
            ST_ARC_L:     state_next = ST_ARC_R;
            ST_ARC_R:     state_next = ST_ARC_SAT;
            ST_ARC_SAT:   state_next = ST_SUM;
            ST_SUM:       state_next = ST_ROT_MUL;
            ST_ROT_MUL:   state_next = ST_ROT_SAT;
            ST_ROT_SAT:   state_next = ST_HEAD;
            ST_HEAD:      state_next = (dt_reg == '0) ? ST_FINISH : ST_RATE_MUL;
            ST_RATE_MUL:  state_next = ST_RATE_HI;
            ST_RATE_HI:   state_next = ST_RATE_LO;
            ST_RATE_LO:   state_next = ST_RATE_ADD;
            ST_RATE_ADD:  state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_sts.done)
                begin
                    state_next = ST_OMEGA;
                end
            end
            ST_OMEGA:     state_next = wheel_reg ? ST_FINISH : ST_RATE_MUL;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // control state, baseline counts, totals and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wheel_reg      <= 1'b0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            dist_reg       <= '0;
            head_reg       <= '0;
            out_valid_reg  <= 1'b0;
            mm_reg         <= MM_PER_COUNT_RST;
            itw_reg        <= INV_TRACK_WIDTH_RST;
            iwr_reg        <= INV_WHEEL_RADIUS_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MM_PER_COUNT:     mm_reg  <= cfg_data;
                    REG_INV_TRACK_WIDTH:  itw_reg <= cfg_data;
                    REG_INV_WHEEL_RADIUS: iwr_reg <= cfg_data;
                    default:              mm_reg  <= mm_reg;
                endcase
            end

            if (in_fire)
            begin
                prev_left_reg  <= COUNT_WIDTH'(left_count);
                prev_right_reg <= COUNT_WIDTH'(right_count);
                // reset action starts the totals over
                if (action)
                begin
                    dist_reg <= '0;
                    head_reg <= '0;
                end
            end

            if (state_reg == ST_ROT_MUL)
            begin
                dist_reg <= dist_sum[ACC_W] ? ACC_U_MAX : dist_sum[ACC_W-1:0];
            end

            if (state_reg == ST_HEAD)
            begin
                wheel_reg <= 1'b0;
                if (head_sum[ACC_W] != head_sum[ACC_W-1])
                begin
                    head_reg <= head_sum[ACC_W] ? $signed(ACC_S_MIN) : $signed(ACC_S_MAX);
                end
                else
                begin
                    head_reg <= head_sum[ACC_W-1:0];
                end
            end

            if (state_reg == ST_OMEGA)
            begin
                wheel_reg <= 1'b1;
            end

            // hand the finished beat to the output register
            if (state_reg == ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    mag_l_reg <= dl_ext[ARC_W-1:0];
                    mag_r_reg <= dr_ext[ARC_W-1:0];
                    ovf_l_reg <= |dl_ext[MAG_EXT_W-1:ARC_W];
                    ovf_r_reg <= |dr_ext[MAG_EXT_W-1:ARC_W];
                    neg_l_reg <= dl[COUNT_WIDTH-1];
                    neg_r_reg <= dr[COUNT_WIDTH-1];
                    dt_reg    <= dt_us;
                    // a reset action reports all zeros
                    fwd_reg   <= '0;
                    rot_reg   <= '0;
                    om_l_reg  <= '0;
                    om_r_reg  <= '0;
                    dtz_reg   <= 1'b0;
                end
            end
            ST_ARC_R:
            begin
                amag_l_reg <= arc_mag_new;
                arc_l_reg  <= neg_l_reg ? $signed(~arc_mag_new + 1'b1) : $signed(arc_mag_new);
            end
            ST_ARC_SAT:
            begin
                amag_r_reg <= arc_mag_new;
                arc_r_reg  <= neg_r_reg ? $signed(~arc_mag_new + 1'b1) : $signed(arc_mag_new);
            end
            ST_SUM:
            begin
                fwd_reg  <= fwd_sum[ARC_W:1];
                diff_reg <= (ARC_W+1)'(arc_r_reg) - (ARC_W+1)'(arc_l_reg);
            end
            ST_ROT_SAT:
            begin
                rot_reg <= rot_new;
            end
            ST_HEAD:
            begin
                om_l_reg <= '0;
                om_r_reg <= '0;
                dtz_reg  <= (dt_reg == '0);
            end
            ST_RATE_HI:
            begin
                lo_reg <= prod[P1_LO_W-1:0];
            end
            ST_RATE_LO:
            begin
                hi_reg <= prod[HI_PROD_W-1:0];
            end
            ST_RATE_ADD:
            begin
                n_reg <= n_full[N_FULL_W-1:CFG_W];
            end
            ST_OMEGA:
            begin
                if (wheel_reg)
                begin
                    om_r_reg <= om_new;
                end
                else
                begin
                    om_l_reg <= om_new;
                end
            end
            default:
            begin
                dt_reg <= dt_reg;
            end
        endcase

        if (state_reg == ST_FINISH && out_free)
        begin
            fwd_out_reg  <= fwd_reg;
            rot_out_reg  <= rot_reg;
            oml_out_reg  <= om_l_reg;
            omr_out_reg  <= om_r_reg;
            dist_out_reg <= dist_reg;
            head_out_reg <= head_reg;
            dtz_out_reg  <= dtz_reg;
        end
    end

    odo_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    odo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (dt_reg),
        .quotient (div_q),
        .sts      (div_sts)
    );

    assign out_valid      = out_valid_reg;
    assign fwd_change     = fwd_out_reg;
    assign rot_change     = rot_out_reg;
    assign omega_left     = oml_out_reg;
    assign omega_right    = omr_out_reg;
    assign distance_total = dist_out_reg;
    assign heading_total  = head_out_reg;
    assign dt_zero        = dtz_out_reg;

`ifndef SYNTHESIS
    // the divider only reports while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider done outside of wait state");

    // a reset action goes straight to hand-off
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && action) |=> state_reg == ST_FINISH)
        else $error("reset action did not go to hand-off");

    // a stalled result is never overwritten by the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !out_ready) |=> state_reg == ST_FINISH)
        else $error("result handed off while output stalled");

    // zero period reports zero rates
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dt_zero) |-> (omega_left == '0 && omega_right == '0))
        else $error("nonzero rate with zero period");

    // the divider is never started while the period is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> dt_reg != '0)
        else $error("divider started with zero period");
`endif

endmodule

// ----- src/odo_mul.sv -----
// ----------------------------------------------------------------------------
// odo_mul: shared signed multiplier
// one product per enabled cycle, held in a register until the next one
// ----------------------------------------------------------------------------
module odo_mul (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [odo_pkg::MUL_A_W-1:0]  a,
    input  logic signed [odo_pkg::MUL_B_W-1:0]  b,
    output logic signed [odo_pkg::MUL_P_W-1:0]  prod
);
    import odo_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

// ----- src/odo_div.sv -----
// ----------------------------------------------------------------------------
// odo_div: iterative unsigned divider for the wheel rates
// restoring division, two quotient bits per cycle, overflow flag when the
// quotient does not fit
// ----------------------------------------------------------------------------
module odo_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [odo_pkg::DIV_N_W-1:0]        dividend,
    input  logic [odo_pkg::DIV_R_W-1:0]        divisor,
    output logic [odo_pkg::DIV_Q_W-1:0]        quotient,
    output odo_pkg::div_sts_t                  sts
);
    import odo_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 ovf_reg;
    logic [DIV_CNT_W-1:0] count_reg;
    logic [DIV_R_W-1:0]   rem_reg;
    logic [DIV_Q_W-1:0]   bits_reg;

    logic [DIV_R_W:0]     t1;
    logic [DIV_R_W:0]     t2;
    logic [DIV_R_W:0]     d1;
    logic [DIV_R_W:0]     d2;
    logic                 ge1;
    logic                 ge2;
    logic [DIV_R_W-1:0]   r1;
    logic [DIV_R_W-1:0]   rem_next;
    logic [DIV_Q_W-1:0]   bits_next;

    // two dependent restoring steps
    always_comb
    begin
        t1        = {rem_reg, bits_reg[DIV_Q_W-1]};
        d1        = t1 - {1'b0, divisor};
        ge1       = (t1 >= {1'b0, divisor});
        r1        = ge1 ? d1[DIV_R_W-1:0] : t1[DIV_R_W-1:0];
        t2        = {r1, bits_reg[DIV_Q_W-2]};
        d2        = t2 - {1'b0, divisor};
        ge2       = (t2 >= {1'b0, divisor});
        rem_next  = ge2 ? d2[DIV_R_W-1:0] : t2[DIV_R_W-1:0];
        bits_next = {bits_reg[DIV_Q_W-3:0], ge1, ge2};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                ovf_reg   <= (dividend[DIV_N_W-1:DIV_Q_W] >= divisor);
                count_reg <= DIV_CNT_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial remainder and dividend bits, quotient shifts in from the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend[DIV_N_W-1:DIV_Q_W];
            bits_reg <= dividend[DIV_Q_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            bits_reg <= bits_next;
        end
    end

    assign quotient = bits_reg;
    assign sts.done = done_reg;
    assign sts.ovf  = ovf_reg;

endmodule
